>>> rtl/bilinear_image_resize_unit_assert.svh
// Assertion macros for the checker file of the bilinear resize block.
`ifndef BILINEAR_IMAGE_RESIZE_UNIT_ASSERT_SVH
`define BILINEAR_IMAGE_RESIZE_UNIT_ASSERT_SVH

// Check on every clock outside reset.
`define BIR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bilinear resize check failed");

// Check on every clock, reset included.
`define BIR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bilinear resize reset check failed");

`endif

>>> rtl/bir_pkg.sv
// ----------------------------------------------------------------------------
// bir_pkg
// Types and constants of the bilinear image resize unit.
// ----------------------------------------------------------------------------
package bir_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int SIZE_IN_W  = 9;
  localparam int SIZE_OUT_W = 13;
  localparam int RATIO_W    = 24;
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int PIXEL_W    = 3 * CHAN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = RATIO_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_RATIO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RATIO    = 3'd5;
  // unmapped indexes; writes to them are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B    = 3'd7;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              out_of_range;
  } out_item_t;

endpackage

>>> rtl/bir_ram.sv
// ----------------------------------------------------------------------------
// bir_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> rtl/bilinear_image_resize_unit.sv
// ----------------------------------------------------------------------------
// bilinear_image_resize_unit
// Loads RGB pixels into an image store and answers bilinear resize queries.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat
//  in      | input     | in_valid / in_stall  | load pixel or query coordinate
//  out     | output    | out_valid / out_stall| one interpolated pixel per query
//  cfg     | input     | cfg_write            | register index and data
//
//  One item per clock while in_stall is low. A query result passes ratio
//  multiply, index clamp and address, store read, x interpolation, then y
//  interpolation into the output queue. Loads write the store in the read
//  stage. The store is two copies of the image, each with two read ports,
//  which give the four neighbors in the same cycle. Reset is synchronous;
//  the store is not cleared. in_stall rises only when 8 query results are
//  in flight or queued.
// ----------------------------------------------------------------------------
module bilinear_image_resize_unit #(
  parameter int MAX_WIDTH  = bir_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bir_pkg::MAX_HEIGHT_DEF,
  parameter int FRAC_BITS  = bir_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  bir_pkg::in_item_t                     in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output bir_pkg::out_item_t                    out_data,
  input  logic                                  cfg_write,
  input  logic [bir_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int XI    = $clog2(MAX_WIDTH);
  localparam int YI    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int PW    = bir_pkg::RATIO_W + bir_pkg::COORD_W;
  localparam int IW    = PW - FRAC_BITS;
  localparam int FW1   = FRAC_BITS + 1;
  localparam int LW    = FRAC_BITS + 9;
  localparam int SW    = 2 * FRAC_BITS + 10;
  localparam int CW    = bir_pkg::CHAN_W;
  localparam int OCC_W = $clog2(bir_pkg::FIFO_DEPTH + 1);
  localparam logic [bir_pkg::RATIO_W-1:0] RATIO_ONE =
    bir_pkg::RATIO_W'(64'(1) << FRAC_BITS);
  localparam logic [FW1-1:0] ONE_FIX = FW1'(1) << FRAC_BITS;

  // Configuration registers
  logic [bir_pkg::SIZE_IN_W-1:0]  in_width, in_height;
  logic [bir_pkg::SIZE_OUT_W-1:0] out_width, out_height;
  logic [bir_pkg::RATIO_W-1:0]    x_ratio, y_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= bir_pkg::SIZE_IN_W'(1);
      in_height  <= bir_pkg::SIZE_IN_W'(1);
      out_width  <= bir_pkg::SIZE_OUT_W'(1);
      out_height <= bir_pkg::SIZE_OUT_W'(1);
      x_ratio    <= RATIO_ONE;
      y_ratio    <= RATIO_ONE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bir_pkg::REG_IN_WIDTH:   in_width   <= cfg_data[bir_pkg::SIZE_IN_W-1:0];
        bir_pkg::REG_IN_HEIGHT:  in_height  <= cfg_data[bir_pkg::SIZE_IN_W-1:0];
        bir_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data[bir_pkg::SIZE_OUT_W-1:0];
        bir_pkg::REG_OUT_HEIGHT: out_height <= cfg_data[bir_pkg::SIZE_OUT_W-1:0];
        bir_pkg::REG_X_RATIO:    x_ratio    <= cfg_data;
        bir_pkg::REG_Y_RATIO:    y_ratio    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective source size
  logic [WW-1:0] w, wm;
  logic [HW-1:0] h, hm;
  logic [TW-1:0] total;

  always_comb begin
    if (in_width == '0) begin
      w = WW'(1);
    end else if (32'(in_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(in_width);
    end
    if (in_height == '0) begin
      h = HW'(1);
    end else if (32'(in_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(in_height);
    end
    wm    = w - WW'(1);
    hm    = h - HW'(1);
    total = TW'(32'(w) * 32'(h));
  end

  // Input handshake and result credits
  logic             accept;
  logic             pop;
  logic             push;
  logic [OCC_W-1:0] occ;

  assign in_stall = (occ == OCC_W'(bir_pkg::FIFO_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(accept && in_data.mode == bir_pkg::MODE_QUERY) - OCC_W'(pop);
    end
  end

  // Load pointer
  logic [AW-1:0] load_pointer, load_pointer_next, lp_eff;
  logic [TW-1:0] lp_inc;

  always_comb begin
    lp_eff = (TW'(load_pointer) >= total) ? '0 : load_pointer;
    lp_inc = TW'(lp_eff) + TW'(1);
    load_pointer_next = (lp_inc >= total) ? '0 : AW'(lp_inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer <= '0;
    end else if (accept && in_data.mode == bir_pkg::MODE_LOAD) begin
      load_pointer <= load_pointer_next;
    end
  end

  // Stage 1: source position
  logic                    v1, q1, oor1;
  logic [AW-1:0]           waddr1;
  logic [bir_pkg::PIXEL_W-1:0] pix1;
  logic [PW-1:0]           px1, py1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    q1     <= in_data.mode;
    pix1   <= {in_data.red_in, in_data.green_in, in_data.blue_in};
    waddr1 <= lp_eff;
    oor1   <= ({1'b0, in_data.out_x} >= out_width) || ({1'b0, in_data.out_y} >= out_height);
    px1    <= PW'(in_data.out_x) * PW'(x_ratio);
    py1    <= PW'(in_data.out_y) * PW'(y_ratio);
  end

  // Stage 2: clamp neighbor indexes, form addresses
  logic [IW-1:0] ix, iy;
  logic [XI-1:0] xl, xh;
  logic [YI-1:0] yl, yh;

  always_comb begin
    ix = px1[PW-1:FRAC_BITS];
    iy = py1[PW-1:FRAC_BITS];
    xl = (32'(ix) > 32'(wm)) ? XI'(wm) : XI'(ix);
    yl = (32'(iy) > 32'(hm)) ? YI'(hm) : YI'(iy);
    xh = (32'(xl) + 32'd1 > 32'(wm)) ? XI'(wm) : XI'(32'(xl) + 32'd1);
    yh = (32'(yl) + 32'd1 > 32'(hm)) ? YI'(hm) : YI'(32'(yl) + 32'd1);
  end

  logic                        v2, q2, oor2;
  logic [AW-1:0]               waddr2, addr_a, addr_b, addr_c, addr_d;
  logic [bir_pkg::PIXEL_W-1:0] pix2;
  logic [FRAC_BITS-1:0]        wx2, wy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    q2     <= q1;
    oor2   <= oor1;
    pix2   <= pix1;
    waddr2 <= waddr1;
    wx2    <= px1[FRAC_BITS-1:0];
    wy2    <= py1[FRAC_BITS-1:0];
    addr_a <= AW'(32'(yl) * 32'(w) + 32'(xl));
    addr_b <= AW'(32'(yl) * 32'(w) + 32'(xh));
    addr_c <= AW'(32'(yh) * 32'(w) + 32'(xl));
    addr_d <= AW'(32'(yh) * 32'(w) + 32'(xh));
  end

  // Stage 3: store access; loads write both copies here, in item order
  logic                        store_we;
  logic [bir_pkg::PIXEL_W-1:0] pa, pb, pc, pd;

  assign store_we = v2 && (q2 == bir_pkg::MODE_LOAD);

  bir_ram #(
    .WIDTH(bir_pkg::PIXEL_W),
    .DEPTH(DEPTH)
  ) u_ram_top (
    .clk    (clk),
    .we     (store_we),
    .waddr  (waddr2),
    .wdata  (pix2),
    .raddr0 (addr_a),
    .raddr1 (addr_b),
    .rdata0 (pa),
    .rdata1 (pb)
  );

  bir_ram #(
    .WIDTH(bir_pkg::PIXEL_W),
    .DEPTH(DEPTH)
  ) u_ram_bot (
    .clk    (clk),
    .we     (store_we),
    .waddr  (waddr2),
    .wdata  (pix2),
    .raddr0 (addr_c),
    .raddr1 (addr_d),
    .rdata0 (pc),
    .rdata1 (pd)
  );

  logic                 v3, q3, oor3;
  logic [FRAC_BITS-1:0] wx3, wy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    q3   <= q2;
    oor3 <= oor2;
    wx3  <= wx2;
    wy3  <= wy2;
  end

  // Stage 4: interpolate along x
  logic                 v4, q4, oor4;
  logic [FRAC_BITS-1:0] wy4;
  logic [LW-1:0]        ab4 [3];
  logic [LW-1:0]        cd4 [3];
  logic [FW1-1:0]       iwx;

  assign iwx = ONE_FIX - FW1'(wx3);

  for (genvar c = 0; c < 3; c++) begin : g_xlerp
    localparam int SH = 16 - 8 * c;
    always_ff @(posedge clk) begin
      ab4[c] <= LW'(pa[SH+:CW]) * LW'(iwx) + LW'(pb[SH+:CW]) * LW'(wx3);
      cd4[c] <= LW'(pc[SH+:CW]) * LW'(iwx) + LW'(pd[SH+:CW]) * LW'(wx3);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    q4   <= q3;
    oor4 <= oor3;
    wy4  <= wy3;
  end

  // Stage 5: interpolate along y, truncate, queue
  logic [FW1-1:0]  iwy;
  logic [CW-1:0]   chan [3];
  bir_pkg::out_item_t result;

  assign iwy = ONE_FIX - FW1'(wy4);

  for (genvar c = 0; c < 3; c++) begin : g_ylerp
    logic [SW-1:0] sum;
    assign sum     = SW'(ab4[c]) * SW'(iwy) + SW'(cd4[c]) * SW'(wy4);
    assign chan[c] = oor4 ? '0 : sum[2*FRAC_BITS +: CW];
  end

  always_comb begin
    result.red_out      = chan[0];
    result.green_out    = chan[1];
    result.blue_out     = chan[2];
    result.out_of_range = oor4;
  end

  assign push = v4 && (q4 == bir_pkg::MODE_QUERY);

  // Result queue; credits keep it from overflowing
  bir_pkg::out_item_t          fifo [bir_pkg::FIFO_DEPTH];
  logic [bir_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [OCC_W-1:0]            count;

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bir_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bir_pkg::FIFO_AW'(1);
      end
      count <= count + OCC_W'(push) - OCC_W'(pop);
    end
  end

  assign out_valid = (count != '0);
  assign out_data  = fifo[rd_ptr];

endmodule

>>> rtl/bir_checker.sv
// ----------------------------------------------------------------------------
// bir_checker
// Port-level checks of the bilinear image resize unit.
// ----------------------------------------------------------------------------
`include "bilinear_image_resize_unit_assert.svh"

module bir_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input bir_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bir_pkg::out_item_t out_data
);

  // Hold a stalled output beat.
  `BIR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data))

  // Drop all results on reset and leave the input open.
  `BIR_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid && !in_stall)

  // Out-of-range results carry zero channels.
  `BIR_ASSERT(a_oor_zero, out_valid && out_data.out_of_range |->
    out_data.red_out == '0 && out_data.green_out == '0 && out_data.blue_out == '0)

  // A fresh result follows a query beat by the fixed pipeline depth.
  `BIR_ASSERT(a_result_source, $rose(out_valid) |->
    $past(in_valid && !in_stall && in_data.mode == bir_pkg::MODE_QUERY, 5))

endmodule

bind bilinear_image_resize_unit bir_checker u_bir_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
